[hdl/gxb_pkg.sv]
// ----------------------------------------------------------------------------
// gxb_pkg
// Shared types and constants for the GF(2) XOR basis span test block.
// ----------------------------------------------------------------------------
package gxb_pkg;

  localparam int VEC_BITS_DEF = 62;
  localparam int RANK_BITS    = 6;
  localparam int OUT_BITS     = 8;
  localparam int USER_BITS    = 2;

  // control that rides with a vector from cell to cell
  typedef struct packed {
    logic valid;
    logic ins;    // insert if independent
    logic start;  // empty the basis before this word
    logic cap;    // word already stored as a row upstream
  } ctrl_t;

endpackage

[hdl/gxb_cell.sv]
// ----------------------------------------------------------------------------
// gxb_cell
// One basis row, owning leading bit BIT. Reduces the passing vector by its
// row, or stores it when the row is free and the word inserts.
// ----------------------------------------------------------------------------
module gxb_cell #(
  parameter int VEC_BITS = gxb_pkg::VEC_BITS_DEF,
  parameter int BIT      = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  gxb_pkg::ctrl_t       in_ctrl,
  input  logic [VEC_BITS-1:0]  in_vec,
  output gxb_pkg::ctrl_t       out_ctrl,
  output logic [VEC_BITS-1:0]  out_vec,
  output logic                 occupied
);
  import gxb_pkg::*;

  logic [VEC_BITS-1:0] row;
  logic                row_valid;
  logic                eff_valid;
  logic                hit;
  logic                capture;
  logic [VEC_BITS-1:0] vec_next;
  ctrl_t               ctrl_next;

  always_comb begin
    // a start word sees this row as already cleared
    eff_valid = row_valid && !in_ctrl.start;
    hit       = in_vec[BIT];
    capture   = in_ctrl.valid && hit && !eff_valid && in_ctrl.ins && !in_ctrl.cap;
    vec_next  = (hit && eff_valid) ? (in_vec ^ row) : in_vec;
    ctrl_next = in_ctrl;
    ctrl_next.cap = in_ctrl.cap | capture;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      out_ctrl  <= '0;
    end else if (adv) begin
      out_ctrl <= ctrl_next;
      if (capture) begin
        row_valid <= 1'b1;
      end else if (in_ctrl.valid && in_ctrl.start) begin
        row_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec <= vec_next;
      if (capture) begin
        row <= in_vec;
      end
    end
  end

  assign occupied = row_valid;

endmodule

[hdl/gf2_xor_basis_span_test_core.sv]
// ----------------------------------------------------------------------------
// gf2_xor_basis_span_test_core
// Span membership test and incremental insert for a GF(2) vector basis.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vector word: tdata holds vec_value, tuser holds
//   req_type (bit 0) and start_new_set (bit 1). m_axis returns one word per
//   input word: in_span in bit 0, rank_after in bits 6:1.
//   The vector runs down a chain of VEC_BITS cells, one per leading bit,
//   highest bit first, one cell per cycle while the chain advances. A free
//   cell stores an inserting vector as its row; a start word clears each
//   row as it passes, so words still in flight ahead of it see the old basis.
//   A word passes the VEC_BITS cell registers and the output register before
//   m_axis_tvalid; a new word is taken every cycle unless m_axis stalls.
//   Reset empties the basis and drops all words in flight.
//   While an output word waits on m_axis_tready the whole chain holds and
//   s_axis_tready stays low; no word is lost or repeated.
// ----------------------------------------------------------------------------
module gf2_xor_basis_span_test_core #(
  parameter int VEC_BITS = gxb_pkg::VEC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((VEC_BITS+7)/8)*8-1:0]    s_axis_tdata,  // vec_value
  input  logic [gxb_pkg::USER_BITS-1:0]    s_axis_tuser,  // req_type, start_new_set
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gxb_pkg::OUT_BITS-1:0]     m_axis_tdata   // in_span, rank_after
);
  import gxb_pkg::*;

  logic                adv;
  ctrl_t               stage_ctrl [VEC_BITS+1];
  logic [VEC_BITS-1:0] stage_vec  [VEC_BITS+1];
  logic [VEC_BITS-1:0] occ;
  logic [RANK_BITS-1:0] rank;
  logic [RANK_BITS-1:0] rank_next;
  logic                 busy;
  ctrl_t                last_ctrl;
  logic [VEC_BITS-1:0]  last_vec;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    stage_ctrl[0]       = '0;
    stage_ctrl[0].valid = s_axis_tvalid;
    stage_ctrl[0].ins   = s_axis_tuser[0];
    stage_ctrl[0].start = s_axis_tuser[1];
    stage_vec[0]        = s_axis_tdata[VEC_BITS-1:0];
  end

  for (genvar i = 0; i < VEC_BITS; i++) begin : g_cell
    gxb_cell #(
      .VEC_BITS (VEC_BITS),
      .BIT      (VEC_BITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctrl  (stage_ctrl[i]),
      .in_vec   (stage_vec[i]),
      .out_ctrl (stage_ctrl[i+1]),
      .out_vec  (stage_vec[i+1]),
      .occupied (occ[VEC_BITS-1-i])
    );
  end

  assign last_ctrl = stage_ctrl[VEC_BITS];
  assign last_vec  = stage_vec[VEC_BITS];
  assign rank_next = (last_ctrl.start ? '0 : rank) + {{(RANK_BITS-1){1'b0}}, last_ctrl.cap};

  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= VEC_BITS; i++) begin
      busy = busy | stage_ctrl[i].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      rank          <= '0;
    end else if (adv) begin
      m_axis_tvalid <= last_ctrl.valid;
      if (last_ctrl.valid) begin
        rank <= rank_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_ctrl.valid) begin
      m_axis_tdata <= {{(OUT_BITS-RANK_BITS-1){1'b0}}, rank_next, (last_vec == '0)};
    end
  end

  // a stored word is independent, so its remainder cannot be zero
  a_cap_nonzero: assert property (@(posedge clk) disable iff (rst)
    (last_ctrl.valid && last_ctrl.cap) |-> (last_vec != '0))
    else $error("stored word reduced to zero");

  // with the chain drained, rank matches the occupied rows
  a_rank_rows: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(occ) == int'(rank)))
    else $error("rank disagrees with occupied rows");

  a_rank_max: assert property (@(posedge clk) disable iff (rst)
    int'(rank) <= VEC_BITS)
    else $error("rank above vector width");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

[tb/gf2_xor_basis_span_test_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_xor_basis_span_test_core_tb
// Self-checking bench for the GF(2) span test core. An in-bench basis model
// predicts in_span and rank_after for every accepted word. Stimulus is built
// as sets that open with a start word, and mixes inserts with span queries.
// Queries use XOR mixes of the stored vectors and random values, and some
// sets fill the whole basis. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module gf2_xor_basis_span_test_core_tb;

  import gxb_pkg::*;

  localparam int VB        = VEC_BITS_DEF;
  localparam int DATA_W    = ((VB + 7) / 8) * 8;
  localparam int LIMIT     = 200000;
  localparam int N_WORDS   = 850;
  localparam int DRAIN_CYC = 2 * VB + 16;

  typedef struct packed {
    logic          ins;
    logic          start;
    logic [VB-1:0] vec;
  } vec_word_t;

  typedef struct packed {
    logic                 in_span;
    logic [RANK_BITS-1:0] rank;
  } span_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;   // vec_value
  logic [USER_BITS-1:0] s_axis_tuser = '0;   // req_type, start_new_set
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;        // in_span, rank_after

  vec_word_t    word_q [$];
  span_result_t span_expect_q [$];

  // in-bench copy of the basis
  logic [VB-1:0]        row_val [VB];
  logic                 row_ok  [VB];
  logic [RANK_BITS-1:0] rank_now;

  int  words_in    = 0;
  int  words_out   = 0;
  int  total_words = 1;
  int  errors      = 0;
  int  cycle_cnt   = 0;
  bit  s_taken     = 1'b0;

  gf2_xor_basis_span_test_core #(
    .VEC_BITS(VB)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_basis();
    for (int b = 0; b < VB; b++) begin
      row_val[b] = '0;
      row_ok[b]  = 1'b0;
    end
    rank_now = '0;
  endfunction

  // reduce high bit first; first free leading bit takes the remainder
  function automatic span_result_t predict_span(input logic ins, input logic start,
                                                input logic [VB-1:0] vec);
    span_result_t r;
    logic [VB-1:0] v;
    int lead;
    if (start) clear_basis();
    v    = vec;
    lead = -1;
    for (int b = VB - 1; b >= 0; b--) begin
      if (v[b]) begin
        if (row_ok[b]) v ^= row_val[b];
        else if (lead < 0) lead = b;
      end
    end
    if (v == '0) begin
      r.in_span = 1'b1;
    end else begin
      r.in_span = 1'b0;
      if (ins && lead >= 0 && !row_ok[lead]) begin
        row_val[lead] = v;
        row_ok[lead]  = 1'b1;
        rank_now      = rank_now + 1'b1;
      end
    end
    r.rank = rank_now;
    return r;
  endfunction

  function automatic int send_idle_pct();
    case (words_in * 3 / total_words)
      0:       return 29;
      1:       return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (words_out * 3 / total_words)
      0:       return 51;
      1:       return 29;
      default: return 0;
    endcase
  endfunction

  task automatic push_word(input logic ins, input logic start, input logic [VB-1:0] v);
    vec_word_t w;
    w.ins   = ins;
    w.start = start;
    w.vec   = v;
    word_q.push_back(w);
  endtask

  function automatic logic [VB-1:0] full_vec();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VB-1:0];
  endfunction

  // mostly dense, some sparse or clustered so reductions collide
  function automatic logic [VB-1:0] rand_vec();
    logic [63:0] r;
    int k;
    k = $urandom_range(0, 9);
    r = {$urandom, $urandom};
    if (k < 5) return r[VB-1:0];
    if (k < 8) begin
      r = '0;
      repeat ($urandom_range(1, 3)) r[$urandom_range(0, VB - 1)] = 1'b1;
      return r[VB-1:0];
    end
    if (k == 8) return {{(VB - 8){1'b0}}, r[7:0]};
    return {r[7:0], {(VB - 8){1'b0}}};
  endfunction

  // one set: start word, then inserts, span-mix words and random queries
  task automatic gen_set(input int len, input int ins_pct, input bit fill);
    logic [VB-1:0] kept [$];
    logic [VB-1:0] v;
    logic ins, start;
    int r;
    for (int i = 0; i < len; i++) begin
      r     = $urandom_range(0, 99);
      start = (i == 0) || ($urandom_range(0, 99) < 3);
      if (start && i != 0) kept.delete();
      if (r < ins_pct) begin
        ins = 1'b1;
        v   = (fill && i < 70) ? full_vec() : rand_vec();
      end else if (kept.size() > 0 && r < ins_pct + (100 - ins_pct) / 2) begin
        ins = ($urandom_range(0, 3) == 0);
        v   = '0;
        foreach (kept[j]) if ($urandom_range(0, 1)) v ^= kept[j];
      end else begin
        ins = 1'b0;
        v   = rand_vec();
      end
      if (ins) kept.push_back(v);
      push_word(ins, start, v);
    end
  endtask

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin : drv
    vec_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_taken) begin
      if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        w = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DATA_W - VB){1'b0}}, w.vec};
        s_axis_tuser  <= {w.start, w.ins};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
  end

  // monitor: check output words, predict on every accepted input word
  always @(posedge clk) begin : mon
    span_result_t exp_r;
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (rst) begin
      s_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (span_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          exp_r = span_expect_q.pop_front();
          if (m_axis_tdata[0] !== exp_r.in_span) begin
            errors++;
            $display("%0t: in_span expected %0b actual %0b", $time, exp_r.in_span,
                     m_axis_tdata[0]);
          end
          if (m_axis_tdata[RANK_BITS:1] !== exp_r.rank) begin
            errors++;
            $display("%0t: rank_after expected %0d actual %0d", $time, exp_r.rank,
                     m_axis_tdata[RANK_BITS:1]);
          end
        end
        words_out++;
      end
      s_taken = s_axis_tvalid && s_axis_tready;
      if (s_taken) begin
        span_expect_q.push_back(predict_span(s_axis_tuser[0], s_axis_tuser[1],
                                             s_axis_tdata[VB-1:0]));
        words_in++;
      end
    end
  end

  initial begin : stim
    logic [VB-1:0] ones;
    logic [VB-1:0] top_bit;
    int set_no;
    ones    = '1;
    top_bit = '0;
    top_bit[VB-1] = 1'b1;
    clear_basis();

    // directed: zero vector, extremes, duplicates, start with query and insert
    push_word(1'b1, 1'b1, '0);
    push_word(1'b0, 1'b0, '0);
    push_word(1'b0, 1'b0, ones);
    push_word(1'b1, 1'b0, ones);
    push_word(1'b0, 1'b0, ones);
    push_word(1'b1, 1'b0, ones);
    push_word(1'b1, 1'b0, top_bit);
    push_word(1'b0, 1'b0, ones ^ top_bit);
    push_word(1'b1, 1'b0, {{(VB - 1){1'b0}}, 1'b1});
    push_word(1'b0, 1'b0, top_bit | 1'b1);
    push_word(1'b0, 1'b0, ones ^ top_bit ^ 1'b1);
    push_word(1'b1, 1'b0, ones ^ top_bit ^ 1'b1);
    push_word(1'b1, 1'b0, '0);
    push_word(1'b0, 1'b1, ones);
    push_word(1'b1, 1'b1, ones);
    push_word(1'b0, 1'b0, '0);
    push_word(1'b1, 1'b1, '0);
    push_word(1'b1, 1'b0, {VB / 2{2'b10}});
    push_word(1'b1, 1'b0, {VB / 2{2'b01}});
    push_word(1'b0, 1'b0, ones);
    push_word(1'b1, 1'b1, top_bit);
    push_word(1'b0, 1'b0, top_bit >> 1);

    set_no = 0;
    while (word_q.size() < N_WORDS) begin
      if (set_no % 4 == 1) gen_set(90, 80, 1'b1);
      else gen_set($urandom_range(4, 40), $urandom_range(20, 70), 1'b0);
      set_no++;
    end
    total_words = word_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (word_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (span_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && span_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
